// ----- rtl/core/mec_pkg.sv -----
`timescale 1ns / 1ps

package mec_pkg;

    // point store geometry
    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // field widths
    localparam int COORD_W = 16;
    localparam int RAD_W   = 16;
    localparam int STAT_W  = 2;
    localparam int RSQ_W   = 40;

    localparam logic [RSQ_W-1:0] RSQ_MAX = '1;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_COLLINEAR = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FEW       = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DROPPED   = 2'd3;

    // stored point word: x low, y high
    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    localparam int POINT_W = $bits(point_t);

endpackage

// ----- rtl/core/mec_in_if.sv -----
`timescale 1ns / 1ps

interface mec_in_if;
    import mec_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);

endinterface

// ----- rtl/core/mec_out_if.sv -----
`timescale 1ns / 1ps

interface mec_out_if;
    import mec_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RAD_W-1:0]          radius;
    logic [STAT_W-1:0]         status;

    modport source (output valid, center_x, center_y, radius, status, input ready);
    modport sink   (input valid, center_x, center_y, radius, status, output ready);

endinterface

// ----- rtl/core/mec_ram.sv -----
`timescale 1ns / 1ps

module mec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/minimum_enclosing_circle.sv -----
`timescale 1ns / 1ps

// minimum enclosing circle of a point set. points (signed q8.8) are taken one
// beat per cycle and written to a 1024-entry point store; extra points are
// dropped and flagged. the beat that carries last_point starts the solve and
// the input stays not ready until its result beat has been handed to the
// output register. the solve is the incremental three-level search: every
// visit of a stored point is a store read, a squared distance on the shared
// 25x36 multiplier and a compare; a two-point circle is built on the same
// multiplier, and a three-point circumcircle takes its squares and products
// on it, two bit-serial divisions and three distance checks. the visit count is between
// n-2 and on the order of n^3/6 for n points, depending on the point order.
// the final radius takes a bit-serial square root and a rounding step. status
// is 0 ok, 1 collinear triple met, 2 fewer than two points, 3 points dropped.
module minimum_enclosing_circle (
    input  logic       clk,
    input  logic       rst_n,
    mec_in_if.sink     points,
    mec_out_if.source  circle
);
    import mec_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE   = 16'b0000_0000_0000_0001,
        S_START  = 16'b0000_0000_0000_0010,
        S_TWO    = 16'b0000_0000_0000_0100,
        S_ITER_I = 16'b0000_0000_0000_1000,
        S_ITER_J = 16'b0000_0000_0001_0000,
        S_ITER_K = 16'b0000_0000_0010_0000,
        S_LOAD   = 16'b0000_0000_0100_0000,
        S_DIST   = 16'b0000_0000_1000_0000,
        S_DCHK   = 16'b0000_0001_0000_0000,
        S_THREE  = 16'b0000_0010_0000_0000,
        S_TDEC   = 16'b0000_0100_0000_0000,
        S_DIV    = 16'b0000_1000_0000_0000,
        S_DFIN   = 16'b0001_0000_0000_0000,
        S_SQRT   = 16'b0010_0000_0000_0000,
        S_ROUND  = 16'b0100_0000_0000_0000,
        S_OUT    = 16'b1000_0000_0000_0000
    } state_t;

    // which loop level issued the current point visit
    typedef enum logic [1:0] {
        ROLE_INIT,
        ROLE_I,
        ROLE_J,
        ROLE_K
    } role_t;

    localparam logic [5:0] DIV_LAST  = 6'd55;
    localparam logic [5:0] SQRT_LAST = 6'd19;

    // control
    state_t            state_reg, state_next;
    role_t             role_reg, role_next;
    logic [5:0]        stp_reg, stp_next;
    logic              rad_reg, rad_next;
    logic [1:0]        ridx_reg, ridx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [1:0]        err_reg, err_next;
    logic              ov_reg, ov_next;

    // circle state: doubled center, (2r)^2
    logic signed [31:0] cx2_reg, cx2_next;
    logic signed [31:0] cy2_reg, cy2_next;
    logic [RSQ_W-1:0]   rsq_reg, rsq_next;

    // points
    point_t p0_reg, p0_next;
    point_t p1_reg, p1_next;
    point_t pi_reg, pi_next;
    point_t pj_reg, pj_next;
    point_t pk_reg, pk_next;
    point_t t_reg, t_next;
    point_t ta_reg, ta_next;
    point_t tb_reg, tb_next;

    // shared multiplier and accumulator
    logic signed [24:0] mul_a;
    logic signed [35:0] mul_b;
    logic signed [60:0] prod_reg, prod_next;
    logic signed [60:0] acc_reg, acc_next;

    // distance unit
    logic signed [24:0] da_reg, da_next;
    logic signed [24:0] db_reg, db_next;
    logic               big_reg, big_next;
    logic [RSQ_W-1:0]   d2_reg, d2_next;
    logic [RSQ_W-1:0]   rmax_reg, rmax_next;

    // circumcircle terms
    logic [33:0]        bb_reg, bb_next;
    logic [33:0]        cc_reg, cc_next;
    logic [33:0]        qr_reg, qr_next;
    logic signed [35:0] d_reg, d_next;
    logic signed [53:0] nx_reg, nx_next;
    logic signed [53:0] ny_reg, ny_next;

    // divider
    logic [55:0] num_reg, num_next;
    logic [55:0] quo_reg, quo_next;
    logic [35:0] rem_reg, rem_next;
    logic [35:0] dv_reg, dv_next;
    logic        neg_reg, neg_next;
    logic        dsel_reg, dsel_next;

    // square root and rounding
    logic [39:0]      sv_reg, sv_next;
    logic [39:0]      sr_reg, sr_next;
    logic [39:0]      sbit_reg, sbit_next;
    logic [RAD_W-1:0] rnd_reg, rnd_next;

    // output register
    logic signed [COORD_W-1:0] ocx_reg, ocx_next;
    logic signed [COORD_W-1:0] ocy_reg, ocy_next;
    logic [RAD_W-1:0]          orad_reg, orad_next;
    logic [STAT_W-1:0]         ostat_reg, ostat_next;

    // memory
    logic              mem_we;
    logic [ADDR_W-1:0] mem_raddr;
    point_t            mem_rdata;
    point_t            in_pt;

    // datapath helpers
    logic               accept_in;
    logic signed [16:0] tdx, tdy, tsx, tsy;
    logic signed [16:0] bx, by, cx, cy, ex, ey;
    logic signed [33:0] ax, ay;
    logic [33:0]        ax_mag, ay_mag;
    logic signed [60:0] sum, dif;
    logic [36:0]        rem_sh;
    logic               div_ge;
    logic [36:0]        rem_sub;
    logic [35:0]        d_mag;
    logic signed [57:0] q_signed;
    logic signed [57:0] c_base;
    logic signed [57:0] c_full;
    logic signed [31:0] c_sat;
    logic [40:0]        sq_try;
    logic               sq_ge;
    logic [18:0]        rm;
    logic [19:0]        rm_inc;
    logic [COORD_W-1:0] rsel_x;

    function automatic logic [55:0] div_num(input logic signed [53:0] n,
                                            input logic [35:0] ad);
        logic [53:0] an;
        an = n[53] ? 54'(-n) : 54'(n);
        return (56'(an) << 1) + 56'(ad);
    endfunction

    // floor((c2 + 1) / 2), saturated to the coordinate range
    function automatic logic signed [COORD_W-1:0] center_out(input logic signed [31:0] c2);
        logic signed [32:0] v;
        v = (33'(c2) + 33'sd1) >>> 1;
        if (v > 33'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (v < -33'sd32768)
        begin
            return 16'sh8000;
        end
        return v[COORD_W-1:0];
    endfunction

    assign rsel_x = '0;

    assign accept_in    = points.valid & points.ready;
    assign points.ready = (state_reg == S_IDLE);

    assign in_pt.x = points.point_x;
    assign in_pt.y = points.point_y;
    assign mem_we  = accept_in && (cnt_reg < CNT_W'(MAX_POINTS));

    always_comb
    begin
        unique case (state_reg)
            S_ITER_I: mem_raddr = i_reg[ADDR_W-1:0];
            S_ITER_J: mem_raddr = j_reg[ADDR_W-1:0];
            default:  mem_raddr = k_reg[ADDR_W-1:0];
        endcase
    end

    mec_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (in_pt),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // two-point circle terms
    assign tdx = 17'($signed(ta_reg.x)) - 17'($signed(tb_reg.x));
    assign tdy = 17'($signed(ta_reg.y)) - 17'($signed(tb_reg.y));
    assign tsx = 17'($signed(ta_reg.x)) + 17'($signed(tb_reg.x));
    assign tsy = 17'($signed(ta_reg.y)) + 17'($signed(tb_reg.y));

    // circumcircle through p = pj, q = pi, r = pk
    assign bx = 17'($signed(pi_reg.x)) - 17'($signed(pj_reg.x));
    assign by = 17'($signed(pi_reg.y)) - 17'($signed(pj_reg.y));
    assign cx = 17'($signed(pk_reg.x)) - 17'($signed(pj_reg.x));
    assign cy = 17'($signed(pk_reg.y)) - 17'($signed(pj_reg.y));
    assign ex = 17'($signed(pk_reg.x)) - 17'($signed(pi_reg.x));
    assign ey = 17'($signed(pk_reg.y)) - 17'($signed(pi_reg.y));

    // offset of the test point from the doubled center
    assign ax     = (34'($signed(t_reg.x)) <<< 1) - 34'(cx2_reg);
    assign ay     = (34'($signed(t_reg.y)) <<< 1) - 34'(cy2_reg);
    assign ax_mag = ax[33] ? 34'(-ax) : 34'(ax);
    assign ay_mag = ay[33] ? 34'(-ay) : 34'(ay);

    assign sum = acc_reg + prod_reg;
    assign dif = acc_reg - prod_reg;

    // restoring divider, one quotient bit per cycle
    assign rem_sh  = {rem_reg, num_reg[55]};
    assign div_ge  = rem_sh >= {1'b0, dv_reg};
    assign rem_sub = rem_sh - {1'b0, dv_reg};
    assign d_mag   = d_reg[35] ? 36'(-d_reg) : 36'(d_reg);

    assign q_signed = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
    assign c_base   = dsel_reg ? (58'($signed(pj_reg.y)) <<< 1)
                               : (58'($signed(pj_reg.x)) <<< 1);
    assign c_full   = c_base + q_signed;

    always_comb
    begin
        if (c_full > 58'sd2147483647)
        begin
            c_sat = 32'sh7FFF_FFFF;
        end
        else if (c_full < -58'sd2147483648)
        begin
            c_sat = 32'sh8000_0000;
        end
        else
        begin
            c_sat = c_full[31:0];
        end
    end

    // square root digit step
    assign sq_try = {1'b0, sr_reg} + {1'b0, sbit_reg};
    assign sq_ge  = {1'b0, sv_reg} >= sq_try;
    assign rm     = sr_reg[19:1];
    assign rm_inc = 20'(rm) + 20'($signed({21'b0, rsq_reg}) >= prod_reg);

    always_comb
    begin
        state_next = state_reg;
        role_next  = role_reg;
        stp_next   = stp_reg;
        rad_next   = rad_reg;
        ridx_next  = ridx_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        err_next   = err_reg;
        ov_next    = ov_reg;
        cx2_next   = cx2_reg;
        cy2_next   = cy2_reg;
        rsq_next   = rsq_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        pi_next    = pi_reg;
        pj_next    = pj_reg;
        pk_next    = pk_reg;
        t_next     = t_reg;
        ta_next    = ta_reg;
        tb_next    = tb_reg;
        acc_next   = acc_reg;
        da_next    = da_reg;
        db_next    = db_reg;
        big_next   = big_reg;
        d2_next    = d2_reg;
        rmax_next  = rmax_reg;
        bb_next    = bb_reg;
        cc_next    = cc_reg;
        qr_next    = qr_reg;
        d_next     = d_reg;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dv_next    = dv_reg;
        neg_next   = neg_reg;
        dsel_next  = dsel_reg;
        sv_next    = sv_reg;
        sr_next    = sr_reg;
        sbit_next  = sbit_reg;
        rnd_next   = rnd_reg;
        ocx_next   = ocx_reg;
        ocy_next   = ocy_reg;
        orad_next  = orad_reg;
        ostat_next = ostat_reg;
        mul_a      = '0;
        mul_b      = '0;

        if (ov_reg && circle.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    if (cnt_reg < CNT_W'(MAX_POINTS))
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (cnt_reg == CNT_W'(0))
                        begin
                            p0_next = in_pt;
                        end
                        if (cnt_reg == CNT_W'(1))
                        begin
                            p1_next = in_pt;
                        end
                    end
                    else
                    begin
                        err_next[1] = 1'b1;
                    end
                    if (points.last_point)
                    begin
                        state_next = S_START;
                    end
                end
            end

            S_START:
            begin
                if (cnt_reg < CNT_W'(2))
                begin
                    // single point or empty set: no search
                    cx2_next   = (cnt_reg != '0) ? (32'($signed(p0_reg.x)) <<< 1) : '0;
                    cy2_next   = (cnt_reg != '0) ? (32'($signed(p0_reg.y)) <<< 1) : '0;
                    rsq_next   = '0;
                    sv_next    = '0;
                    sr_next    = '0;
                    sbit_next  = 40'd1 << 38;
                    stp_next   = '0;
                    state_next = S_SQRT;
                end
                else
                begin
                    ta_next    = p0_reg;
                    tb_next    = p1_reg;
                    role_next  = ROLE_INIT;
                    stp_next   = '0;
                    state_next = S_TWO;
                end
            end

            S_TWO:
            begin
                case (stp_reg)
                    6'd0:
                    begin
                        mul_a    = 25'(tdx);
                        mul_b    = 36'(tdx);
                        stp_next = 6'd1;
                    end
                    6'd1:
                    begin
                        mul_a    = 25'(tdy);
                        mul_b    = 36'(tdy);
                        acc_next = prod_reg;
                        stp_next = 6'd2;
                    end
                    default:
                    begin
                        rsq_next = sum[RSQ_W-1:0];
                        cx2_next = 32'(tsx);
                        cy2_next = 32'(tsy);
                        unique case (role_reg)
                            ROLE_INIT:
                            begin
                                i_next     = CNT_W'(2);
                                state_next = S_ITER_I;
                            end
                            ROLE_I:
                            begin
                                j_next     = CNT_W'(1);
                                state_next = S_ITER_J;
                            end
                            ROLE_J:
                            begin
                                k_next     = '0;
                                state_next = S_ITER_K;
                            end
                            default:
                            begin
                                k_next     = k_reg + CNT_W'(1);
                                state_next = S_ITER_K;
                            end
                        endcase
                    end
                endcase
            end

            S_ITER_I:
            begin
                role_next = ROLE_I;
                if (i_reg >= cnt_reg)
                begin
                    sv_next    = rsq_reg;
                    sr_next    = '0;
                    sbit_next  = 40'd1 << 38;
                    stp_next   = '0;
                    state_next = S_SQRT;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end

            S_ITER_J:
            begin
                role_next = ROLE_J;
                if (j_reg >= i_reg)
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_ITER_I;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end

            S_ITER_K:
            begin
                role_next = ROLE_K;
                if (k_reg >= j_reg)
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_ITER_J;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end

            S_LOAD:
            begin
                t_next     = mem_rdata;
                rad_next   = 1'b0;
                stp_next   = '0;
                state_next = S_DIST;
            end

            S_DIST:
            begin
                case (stp_reg)
                    6'd0:
                    begin
                        da_next  = ax[24:0];
                        db_next  = ay[24:0];
                        big_next = (ax_mag > 34'hFF_FFFF) || (ay_mag > 34'hFF_FFFF);
                        stp_next = 6'd1;
                    end
                    6'd1:
                    begin
                        mul_a    = da_reg;
                        mul_b    = 36'(da_reg);
                        stp_next = 6'd2;
                    end
                    6'd2:
                    begin
                        mul_a    = db_reg;
                        mul_b    = 36'(db_reg);
                        acc_next = prod_reg;
                        stp_next = 6'd3;
                    end
                    default:
                    begin
                        d2_next    = (big_reg || (sum[60:RSQ_W] != '0)) ? RSQ_MAX
                                                                       : sum[RSQ_W-1:0];
                        state_next = S_DCHK;
                    end
                endcase
            end

            S_DCHK:
            begin
                if (rad_reg)
                begin
                    // radius of a circumcircle: largest distance to its three points
                    logic [RSQ_W-1:0] mx;
                    mx = ((ridx_reg == 2'd0) || (d2_reg > rmax_reg)) ? d2_reg : rmax_reg;
                    if (ridx_reg == 2'd2)
                    begin
                        rsq_next   = mx;
                        rad_next   = 1'b0;
                        k_next     = k_reg + CNT_W'(1);
                        state_next = S_ITER_K;
                    end
                    else
                    begin
                        rmax_next  = mx;
                        ridx_next  = ridx_reg + 2'd1;
                        t_next     = (ridx_reg == 2'd0) ? pi_reg : pk_reg;
                        stp_next   = '0;
                        state_next = S_DIST;
                    end
                end
                else
                begin
                    unique case (role_reg)
                        ROLE_I:
                        begin
                            if (d2_reg > rsq_reg)
                            begin
                                pi_next    = t_reg;
                                ta_next    = t_reg;
                                tb_next    = p0_reg;
                                stp_next   = '0;
                                state_next = S_TWO;
                            end
                            else
                            begin
                                i_next     = i_reg + CNT_W'(1);
                                state_next = S_ITER_I;
                            end
                        end
                        ROLE_J:
                        begin
                            if (d2_reg > rsq_reg)
                            begin
                                pj_next    = t_reg;
                                ta_next    = t_reg;
                                tb_next    = pi_reg;
                                stp_next   = '0;
                                state_next = S_TWO;
                            end
                            else
                            begin
                                j_next     = j_reg + CNT_W'(1);
                                state_next = S_ITER_J;
                            end
                        end
                        ROLE_K:
                        begin
                            if (d2_reg > rsq_reg)
                            begin
                                pk_next    = t_reg;
                                stp_next   = '0;
                                state_next = S_THREE;
                            end
                            else
                            begin
                                k_next     = k_reg + CNT_W'(1);
                                state_next = S_ITER_K;
                            end
                        end
                        default:
                        begin
                            state_next = S_ITER_I;
                        end
                    endcase
                end
            end

            S_THREE:
            begin
                // products land in the step after their operands
                stp_next = stp_reg + 6'd1;
                case (stp_reg)
                    6'd0:
                    begin
                        mul_a = 25'(bx);
                        mul_b = 36'(bx);
                    end
                    6'd1:
                    begin
                        mul_a    = 25'(by);
                        mul_b    = 36'(by);
                        acc_next = prod_reg;
                    end
                    6'd2:
                    begin
                        mul_a   = 25'(cx);
                        mul_b   = 36'(cx);
                        bb_next = sum[33:0];
                    end
                    6'd3:
                    begin
                        mul_a    = 25'(cy);
                        mul_b    = 36'(cy);
                        acc_next = prod_reg;
                    end
                    6'd4:
                    begin
                        mul_a   = 25'(bx);
                        mul_b   = 36'(cy);
                        cc_next = sum[33:0];
                    end
                    6'd5:
                    begin
                        mul_a    = 25'(by);
                        mul_b    = 36'(cx);
                        acc_next = prod_reg;
                    end
                    6'd6:
                    begin
                        mul_a  = 25'(cy);
                        mul_b  = $signed({2'b00, bb_reg});
                        d_next = {dif[34:0], 1'b0};
                    end
                    6'd7:
                    begin
                        mul_a    = 25'(by);
                        mul_b    = $signed({2'b00, cc_reg});
                        acc_next = prod_reg;
                    end
                    6'd8:
                    begin
                        mul_a   = 25'(bx);
                        mul_b   = $signed({2'b00, cc_reg});
                        nx_next = {dif[52:0], 1'b0};
                    end
                    6'd9:
                    begin
                        mul_a    = 25'(cx);
                        mul_b    = $signed({2'b00, bb_reg});
                        acc_next = prod_reg;
                    end
                    6'd10:
                    begin
                        mul_a   = 25'(ex);
                        mul_b   = 36'(ex);
                        ny_next = {dif[52:0], 1'b0};
                    end
                    6'd11:
                    begin
                        mul_a    = 25'(ey);
                        mul_b    = 36'(ey);
                        acc_next = prod_reg;
                    end
                    default:
                    begin
                        qr_next    = sum[33:0];
                        state_next = S_TDEC;
                    end
                endcase
            end

            S_TDEC:
            begin
                stp_next = '0;
                if (d_reg == '0)
                begin
                    // collinear or repeated triple: diameter of the farthest pair
                    err_next[0] = 1'b1;
                    if ((bb_reg >= cc_reg) && (bb_reg >= qr_reg))
                    begin
                        ta_next = pj_reg;
                        tb_next = pi_reg;
                    end
                    else if (cc_reg >= qr_reg)
                    begin
                        ta_next = pj_reg;
                        tb_next = pk_reg;
                    end
                    else
                    begin
                        ta_next = pi_reg;
                        tb_next = pk_reg;
                    end
                    state_next = S_TWO;
                end
                else
                begin
                    num_next   = div_num(nx_reg, d_mag);
                    dv_next    = d_mag << 1;
                    rem_next   = '0;
                    quo_next   = '0;
                    neg_next   = nx_reg[53] ^ d_reg[35];
                    dsel_next  = 1'b0;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                rem_next = div_ge ? rem_sub[35:0] : rem_sh[35:0];
                quo_next = {quo_reg[54:0], div_ge};
                num_next = num_reg << 1;
                stp_next = stp_reg + 6'd1;
                if (stp_reg == DIV_LAST)
                begin
                    state_next = S_DFIN;
                end
            end

            S_DFIN:
            begin
                stp_next = '0;
                if (!dsel_reg)
                begin
                    cx2_next   = c_sat;
                    num_next   = div_num(ny_reg, d_mag);
                    rem_next   = '0;
                    quo_next   = '0;
                    neg_next   = ny_reg[53] ^ d_reg[35];
                    dsel_next  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    cy2_next   = c_sat;
                    rad_next   = 1'b1;
                    ridx_next  = 2'd0;
                    t_next     = pj_reg;
                    state_next = S_DIST;
                end
            end

            S_SQRT:
            begin
                if (sq_ge)
                begin
                    sv_next = sv_reg - sq_try[39:0];
                    sr_next = (sr_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sr_next = sr_reg >> 1;
                end
                sbit_next = sbit_reg >> 2;
                stp_next  = stp_reg + 6'd1;
                if (stp_reg == SQRT_LAST)
                begin
                    stp_next   = '0;
                    state_next = S_ROUND;
                end
            end

            S_ROUND:
            begin
                if (stp_reg == 6'd0)
                begin
                    // (2m+1)^2 decides the round-up
                    mul_a    = $signed({5'b0, rm, 1'b1});
                    mul_b    = $signed({16'b0, rm, 1'b1});
                    stp_next = 6'd1;
                end
                else
                begin
                    rnd_next   = (rm_inc[19:RAD_W] != '0) ? '1 : rm_inc[RAD_W-1:0];
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!ov_reg || circle.ready)
                begin
                    ocx_next  = center_out(cx2_reg);
                    ocy_next  = center_out(cy2_reg);
                    orad_next = rnd_reg;
                    if (cnt_reg < CNT_W'(2))
                    begin
                        ostat_next = STAT_FEW;
                    end
                    else if (err_reg[1])
                    begin
                        ostat_next = STAT_DROPPED;
                    end
                    else if (err_reg[0])
                    begin
                        ostat_next = STAT_COLLINEAR;
                    end
                    else
                    begin
                        ostat_next = STAT_OK;
                    end
                    ov_next    = 1'b1;
                    cnt_next   = '0;
                    err_next   = '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign prod_next = 61'(mul_a) * 61'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            role_reg  <= ROLE_INIT;
            stp_reg   <= '0;
            rad_reg   <= 1'b0;
            ridx_reg  <= '0;
            cnt_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            err_reg   <= '0;
            ov_reg    <= 1'b0;
            cx2_reg   <= '0;
            cy2_reg   <= '0;
            rsq_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            role_reg  <= role_next;
            stp_reg   <= stp_next;
            rad_reg   <= rad_next;
            ridx_reg  <= ridx_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            err_reg   <= err_next;
            ov_reg    <= ov_next;
            cx2_reg   <= cx2_next;
            cy2_reg   <= cy2_next;
            rsq_reg   <= rsq_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        p0_reg    <= p0_next;
        p1_reg    <= p1_next;
        pi_reg    <= pi_next;
        pj_reg    <= pj_next;
        pk_reg    <= pk_next;
        t_reg     <= t_next;
        ta_reg    <= ta_next;
        tb_reg    <= tb_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        da_reg    <= da_next;
        db_reg    <= db_next;
        big_reg   <= big_next;
        d2_reg    <= d2_next;
        rmax_reg  <= rmax_next;
        bb_reg    <= bb_next;
        cc_reg    <= cc_next;
        qr_reg    <= qr_next;
        d_reg     <= d_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        num_reg   <= num_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dv_reg    <= dv_next;
        neg_reg   <= neg_next;
        dsel_reg  <= dsel_next;
        sv_reg    <= sv_next;
        sr_reg    <= sr_next;
        sbit_reg  <= sbit_next;
        rnd_reg   <= rnd_next;
        ocx_reg   <= ocx_next;
        ocy_reg   <= ocy_next;
        orad_reg  <= orad_next;
        ostat_reg <= ostat_next;
    end

    assign circle.valid    = ov_reg;
    assign circle.center_x = ocx_reg | $signed(rsel_x);
    assign circle.center_y = ocy_reg;
    assign circle.radius   = orad_reg;
    assign circle.status   = ostat_reg;

endmodule
